/* design/wscr_pkg.sv */
// shared constants, types and codes for the window stack click-raise unit
package wscr_pkg;

    localparam int WINDOWS  = 16;
    localparam int IDX_W    = $clog2(WINDOWS);
    localparam int CNT_W    = $clog2(WINDOWS + 1);
    localparam int COORD_W  = 16;
    localparam int ID_W     = 16;
    localparam int DEPTH_W  = 4;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int RCMP_W   = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_CLICK = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } t_rect;

    typedef struct packed {
        logic            entry_we;
        logic            rank_we;
        t_idx            addr;
        t_rect           rect;
        logic [ID_W-1:0] id;
        t_idx            rank;
    } t_store_wr;

    typedef struct packed {
        logic in_rect;
        logic rank_lt;
        logic rank_eq;
    } t_cmp_res;

endpackage

/* design/wscr_if.sv */
// request and result channel interfaces
interface wscr_in_if;
    logic                         valid;
    logic                         ready;
    logic [wscr_pkg::MODE_W-1:0]  mode;
    logic [wscr_pkg::ID_W-1:0]    window_id;
    logic [wscr_pkg::COORD_W-1:0] left;
    logic [wscr_pkg::COORD_W-1:0] top;
    logic [wscr_pkg::COORD_W-1:0] right;
    logic [wscr_pkg::COORD_W-1:0] bottom;
    logic [wscr_pkg::COORD_W-1:0] point_x;
    logic [wscr_pkg::COORD_W-1:0] point_y;
    logic [wscr_pkg::DEPTH_W-1:0] depth_query;

    modport source (
        output valid, mode, window_id, left, top, right, bottom, point_x, point_y,
               depth_query,
        input  ready
    );
    modport sink (
        input  valid, mode, window_id, left, top, right, bottom, point_x, point_y,
               depth_query,
        output ready
    );
endinterface

interface wscr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [wscr_pkg::ID_W-1:0]     result_id;
    logic [wscr_pkg::STATUS_W-1:0] status;

    modport source (output valid, hit, result_id, status, input ready);
    modport sink   (input valid, hit, result_id, status, output ready);
endinterface

/* design/wscr_store.sv */
// window table: rectangles, ids and ranks, one write port and one registered read port
module wscr_store (
    input  logic                          i_clk,
    input  wscr_pkg::t_store_wr           i_wr,
    input  wscr_pkg::t_idx                i_rd_addr,
    output wscr_pkg::t_rect               o_rd_rect,
    output logic [wscr_pkg::ID_W-1:0]     o_rd_id,
    output wscr_pkg::t_idx                o_rd_rank
);

    wscr_pkg::t_rect           r_rect [wscr_pkg::WINDOWS];
    logic [wscr_pkg::ID_W-1:0] r_id   [wscr_pkg::WINDOWS];
    wscr_pkg::t_idx            r_rank [wscr_pkg::WINDOWS];

    wscr_pkg::t_rect           r_rd_rect;
    logic [wscr_pkg::ID_W-1:0] r_rd_id;
    wscr_pkg::t_idx            r_rd_rank;

    always_ff @(posedge i_clk) begin
        if (i_wr.entry_we) begin
            r_rect[i_wr.addr] <= i_wr.rect;
            r_id[i_wr.addr]   <= i_wr.id;
            r_rank[i_wr.addr] <= i_wr.rank;
        end else if (i_wr.rank_we) begin
            r_rank[i_wr.addr] <= i_wr.rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_rect <= r_rect[i_rd_addr];
        r_rd_id   <= r_id[i_rd_addr];
        r_rd_rank <= r_rank[i_rd_addr];
    end

    assign o_rd_rect = r_rd_rect;
    assign o_rd_id   = r_rd_id;
    assign o_rd_rank = r_rd_rank;

endmodule

/* design/wscr_cmp.sv */
// shared compare unit: point-in-rectangle test and rank compares for one entry
module wscr_cmp (
    input  logic [wscr_pkg::COORD_W-1:0] i_px,
    input  logic [wscr_pkg::COORD_W-1:0] i_py,
    input  wscr_pkg::t_rect              i_rect,
    input  wscr_pkg::t_idx               i_rank,
    input  wscr_pkg::t_idx               i_best_rank,
    input  logic [wscr_pkg::DEPTH_W-1:0] i_depth,
    output wscr_pkg::t_cmp_res           o_res
);

    always_comb begin
        // degenerate rectangles fail one of the bounds and never hit
        o_res.in_rect = (i_px >= i_rect.left) && (i_py >= i_rect.top) &&
                        (i_px <= i_rect.right) && (i_py <= i_rect.bottom);
        o_res.rank_lt = (i_rank < i_best_rank);
        o_res.rank_eq = (wscr_pkg::RCMP_W'(i_rank) == wscr_pkg::RCMP_W'(i_depth));
    end

endmodule

/* design/window_stack_click_raise_unit.sv */
// window stack click-raise unit: sequencer, request latch and result register
// load, clear, out-of-range read and click on an empty table go from idle straight to the
// done state; read and click first scan the table, and a click that hits adds a raise pass
// one request at a time; the table is scanned one entry per cycle through the shared
// compare unit, once to find the hit or read entry, then on a click hit to shift ranks
// synchronous active-low reset empties the table and clears the output valid
module window_stack_click_raise_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wscr_in_if.sink       i_in,
    wscr_out_if.source    o_out
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_RAISE = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    logic [wscr_pkg::CNT_W-1:0]       r_count, n_count;
    wscr_pkg::t_idx                   r_idx, n_idx;
    wscr_pkg::t_mode                  r_mode, n_mode;
    logic [wscr_pkg::COORD_W-1:0]     r_px, n_px;
    logic [wscr_pkg::COORD_W-1:0]     r_py, n_py;
    logic [wscr_pkg::DEPTH_W-1:0]     r_depth, n_depth;
    logic                             r_found, n_found;
    wscr_pkg::t_idx                   r_best, n_best;
    wscr_pkg::t_idx                   r_best_rank, n_best_rank;
    logic [wscr_pkg::ID_W-1:0]        r_best_id, n_best_id;
    logic                             r_hit, n_hit;
    logic [wscr_pkg::ID_W-1:0]        r_rid, n_rid;
    wscr_pkg::t_status                r_status, n_status;
    logic                             r_out_valid, n_out_valid;
    logic                             r_out_hit, n_out_hit;
    logic [wscr_pkg::ID_W-1:0]        r_out_rid, n_out_rid;
    wscr_pkg::t_status                r_out_status, n_out_status;

    wscr_pkg::t_store_wr              store_wr;
    wscr_pkg::t_rect                  rd_rect;
    logic [wscr_pkg::ID_W-1:0]        rd_id;
    wscr_pkg::t_idx                   rd_rank;
    wscr_pkg::t_cmp_res               cmp_res;
    logic                             last_entry;

    // the table read is registered, so the read address is the next index (n_idx) and the data belongs to r_idx
    wscr_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_addr (n_idx),
        .o_rd_rect (rd_rect),
        .o_rd_id   (rd_id),
        .o_rd_rank (rd_rank)
    );

    wscr_cmp u_cmp (
        .i_px        (r_px),
        .i_py        (r_py),
        .i_rect      (rd_rect),
        .i_rank      (rd_rank),
        .i_best_rank (r_best_rank),
        .i_depth     (r_depth),
        .o_res       (cmp_res)
    );

    assign last_entry = ((wscr_pkg::CNT_W'(r_idx) + wscr_pkg::CNT_W'(1)) == r_count);

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.hit       = r_out_hit;
    assign o_out.result_id = r_out_rid;
    assign o_out.status    = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_mode       = r_mode;
        n_px         = r_px;
        n_py         = r_py;
        n_depth      = r_depth;
        n_found      = r_found;
        n_best       = r_best;
        n_best_rank  = r_best_rank;
        n_best_id    = r_best_id;
        n_hit        = r_hit;
        n_rid        = r_rid;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_hit    = r_out_hit;
        n_out_rid    = r_out_rid;
        n_out_status = r_out_status;

        store_wr.entry_we    = 1'b0;
        store_wr.rank_we     = 1'b0;
        store_wr.addr        = r_idx;
        store_wr.rect.left   = i_in.left;
        store_wr.rect.top    = i_in.top;
        store_wr.rect.right  = i_in.right;
        store_wr.rect.bottom = i_in.bottom;
        store_wr.id          = i_in.window_id;
        store_wr.rank        = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_mode      = wscr_pkg::t_mode'(i_in.mode);
                    n_px        = i_in.point_x;
                    n_py        = i_in.point_y;
                    n_depth     = i_in.depth_query;
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_best      = '0;
                    n_best_rank = '0;
                    n_best_id   = '0;
                    n_hit       = 1'b0;
                    n_rid       = '0;
                    n_status    = wscr_pkg::STATUS_OK;
                    n_state     = ST_DONE;
                    unique case (wscr_pkg::t_mode'(i_in.mode))
                        wscr_pkg::MODE_LOAD: begin
                            if (r_count == wscr_pkg::CNT_W'(wscr_pkg::WINDOWS)) begin
                                n_status = wscr_pkg::STATUS_FULL;
                            end else begin
                                // new window goes to the bottom of the stack
                                store_wr.entry_we = 1'b1;
                                store_wr.addr     = r_count[wscr_pkg::IDX_W-1:0];
                                store_wr.rank     = r_count[wscr_pkg::IDX_W-1:0];
                                n_count           = r_count + wscr_pkg::CNT_W'(1);
                            end
                        end
                        wscr_pkg::MODE_CLICK: begin
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        wscr_pkg::MODE_READ: begin
                            if (wscr_pkg::RCMP_W'(i_in.depth_query) <
                                wscr_pkg::RCMP_W'(r_count)) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_status = wscr_pkg::STATUS_RANGE;
                            end
                        end
                        wscr_pkg::MODE_CLEAR: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_mode == wscr_pkg::MODE_CLICK) begin
                    // keep the topmost containing window seen so far
                    if (cmp_res.in_rect && (!r_found || cmp_res.rank_lt)) begin
                        n_found     = 1'b1;
                        n_best      = r_idx;
                        n_best_rank = rd_rank;
                        n_best_id   = rd_id;
                    end
                end else if (cmp_res.rank_eq) begin
                    n_found   = 1'b1;
                    n_best_id = rd_id;
                end
                n_idx = r_idx + wscr_pkg::IDX_W'(1);
                if (last_entry) begin
                    n_idx = '0;
                    if (r_mode == wscr_pkg::MODE_CLICK && n_found) begin
                        n_state = ST_RAISE;
                    end else begin
                        n_hit   = n_found;
                        n_rid   = n_found ? n_best_id : '0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RAISE: begin
                // windows above the hit one move down a rank, the hit one goes on top
                if (r_idx == r_best) begin
                    store_wr.rank_we = 1'b1;
                    store_wr.rank    = '0;
                end else if (cmp_res.rank_lt) begin
                    store_wr.rank_we = 1'b1;
                    store_wr.rank    = rd_rank + wscr_pkg::IDX_W'(1);
                end
                n_idx = r_idx + wscr_pkg::IDX_W'(1);
                if (last_entry) begin
                    n_idx   = '0;
                    n_hit   = 1'b1;
                    n_rid   = r_best_id;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_hit    = r_hit;
                    n_out_rid    = r_rid;
                    n_out_status = r_status;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_px         <= n_px;
        r_py         <= n_py;
        r_depth      <= n_depth;
        r_found      <= n_found;
        r_best       <= n_best;
        r_best_rank  <= n_best_rank;
        r_best_id    <= n_best_id;
        r_hit        <= n_hit;
        r_rid        <= n_rid;
        r_status     <= n_status;
        r_out_hit    <= n_out_hit;
        r_out_rid    <= n_out_rid;
        r_out_status <= n_out_status;
    end

endmodule
